### sv/fpp_pkg.sv
// Shared types and constants for the framed packet parser.
// No dependencies; fpp_parse, fpp_out_stage and the top level import this package.
package fpp_pkg;

  // Frame start marker looked for while hunting
  localparam logic [7:0] START_BYTE = 8'h3a;

  // Width of the running checksum sum (address + function + length + payload)
  localparam int SUM_W = 25;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2
  } fpp_kind_t;

  // One result item as it leaves the parser
  typedef struct packed {
    fpp_kind_t   kind;
    logic [7:0]  data_byte;
    logic [15:0] frame_address;
    logic [15:0] frame_function;
    logic [15:0] frame_length;
  } fpp_result_t;

endpackage

### sv/fpp_if.sv
// Valid/ready channel interfaces for the framed packet parser.
// fpp_in_if carries received bytes, fpp_out_if carries result items.
// No dependencies.
interface fpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fpp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] frame_address;
  logic [15:0] frame_function;
  logic [15:0] frame_length;

  modport source (output valid, output kind, output data_byte, output frame_address,
                  output frame_function, output frame_length, input ready);
  modport sink   (input valid, input kind, input data_byte, input frame_address,
                  input frame_function, input frame_length, output ready);
endinterface

### sv/fpp_in_stage.sv
// Input register of the framed packet parser: holds one received byte.
// Depends on nothing but the clock and reset.
module fpp_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       pop,
  output logic       in_ready,
  output logic       item_valid,
  output logic [7:0] item_byte
);

  logic       valid_r;
  logic [7:0] byte_r;

  // Take a new byte when empty or when the held byte moves on this cycle
  assign in_ready = !valid_r || pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

  assign item_valid = valid_r;
  assign item_byte  = byte_r;

endmodule

### sv/fpp_parse.sv
// Frame parser state machine: header capture, payload pass-through, checksum.
// Uses fpp_pkg for the start byte, sum width and result type.
module fpp_parse import fpp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  logic [7:0]  item_byte,
  input  logic        advance,
  output logic        res_valid,
  output fpp_result_t res
);

  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_ADDR_LO = 4'd1,
    PH_ADDR_HI = 4'd2,
    PH_FUNC_LO = 4'd3,
    PH_FUNC_HI = 4'd4,
    PH_LEN_LO  = 4'd5,
    PH_LEN_HI  = 4'd6,
    PH_PAYLOAD = 4'd7,
    PH_CHK_HI  = 4'd8
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [15:0]        addr_r, addr_nxt;
  logic [15:0]        func_r, func_nxt;
  logic [15:0]        len_r, len_nxt;
  logic [15:0]        remain_r, remain_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [7:0]         chk_lo_r, chk_lo_nxt;
  logic               emit;
  fpp_kind_t          kind;
  logic [7:0]         data;
  logic [15:0]        rx_chk;

  assign rx_chk = {item_byte, chk_lo_r};

  // Next state and result for the byte held in the input register
  always_comb begin
    phase_nxt  = phase_r;
    addr_nxt   = addr_r;
    func_nxt   = func_r;
    len_nxt    = len_r;
    remain_nxt = remain_r;
    sum_nxt    = sum_r;
    chk_lo_nxt = chk_lo_r;
    emit       = 1'b0;
    kind       = KIND_DATA;
    data       = 8'd0;
    case (phase_r)
      PH_HUNT: begin
        if (item_byte == START_BYTE) begin
          phase_nxt = PH_ADDR_LO;
        end
      end
      PH_ADDR_LO: begin
        addr_nxt  = {8'd0, item_byte};
        phase_nxt = PH_ADDR_HI;
      end
      PH_ADDR_HI: begin
        addr_nxt  = {item_byte, addr_r[7:0]};
        phase_nxt = PH_FUNC_LO;
      end
      PH_FUNC_LO: begin
        func_nxt  = {8'd0, item_byte};
        phase_nxt = PH_FUNC_HI;
      end
      PH_FUNC_HI: begin
        func_nxt  = {item_byte, func_r[7:0]};
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_nxt   = {8'd0, item_byte};
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_nxt    = {item_byte, len_r[7:0]};
        remain_nxt = {item_byte, len_r[7:0]};
        sum_nxt    = SUM_W'(addr_r) + SUM_W'(func_r) + SUM_W'({item_byte, len_r[7:0]});
        phase_nxt  = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (remain_r == 16'd0) begin
          chk_lo_nxt = item_byte;
          phase_nxt  = PH_CHK_HI;
        end else begin
          sum_nxt    = sum_r + SUM_W'(item_byte);
          remain_nxt = remain_r - 16'd1;
          emit       = 1'b1;
          kind       = KIND_DATA;
          data       = item_byte;
        end
      end
      PH_CHK_HI: begin
        phase_nxt = PH_HUNT;
        emit      = 1'b1;
        kind      = (SUM_W'(rx_chk) == sum_r) ? KIND_GOOD : KIND_BAD;
      end
      default: begin
        // Unknown code: drop the byte and go back to hunting
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  assign res_valid          = item_valid && emit;
  assign res.kind           = kind;
  assign res.data_byte      = data;
  assign res.frame_address  = addr_r;
  assign res.frame_function = func_r;
  assign res.frame_length   = len_r;

  // Advance parser state once per byte that leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      addr_r   <= 16'd0;
      func_r   <= 16'd0;
      len_r    <= 16'd0;
      remain_r <= 16'd0;
      sum_r    <= '0;
      chk_lo_r <= 8'd0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      addr_r   <= addr_nxt;
      func_r   <= func_nxt;
      len_r    <= len_nxt;
      remain_r <= remain_nxt;
      sum_r    <= sum_nxt;
      chk_lo_r <= chk_lo_nxt;
    end
  end

endmodule

### sv/fpp_out_stage.sv
// Result register of the framed packet parser, drives the output channel.
// Uses fpp_pkg for the result type.
module fpp_out_stage import fpp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  fpp_result_t res_in,
  input  logic        out_ready,
  output logic        out_free,
  output logic        out_valid,
  output fpp_result_t res_out
);

  logic        valid_r;
  fpp_result_t res_r;

  // Register can take a result when empty or when its transfer completes now
  assign out_free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

### sv/framed_packet_parser_16bit_sum.sv
// Framed packet parser with 16-bit additive checksum: top level.
// A result is offered from the clock edge at which its byte leaves the input register;
// the byte passes through the input register and then the result register.
// One byte per cycle while results are not blocked; the parser updates once per byte.
// Reset: synchronous active-low rst_n empties both registers and returns to hunting.
module framed_packet_parser_16bit_sum import fpp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  fpp_in_if.sink    in_chan,
  fpp_out_if.source out_chan
);

  logic        item_valid;
  logic [7:0]  item_byte;
  logic        res_valid;
  fpp_result_t res;
  fpp_result_t res_q;
  logic        out_free;
  logic        advance;
  logic        load;
  logic        in_ready;

  // Move the held byte on unless it makes a result and the result register is blocked
  assign advance = item_valid && (!res_valid || out_free);
  assign load    = advance && res_valid;

  fpp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_byte    (in_chan.rx_byte),
    .pop        (advance),
    .in_ready   (in_ready),
    .item_valid (item_valid),
    .item_byte  (item_byte)
  );

  assign in_chan.ready = in_ready;

  fpp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_byte  (item_byte),
    .advance    (advance),
    .res_valid  (res_valid),
    .res        (res)
  );

  fpp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .res_in    (res),
    .out_ready (out_chan.ready),
    .out_free  (out_free),
    .out_valid (out_chan.valid),
    .res_out   (res_q)
  );

  assign out_chan.kind           = res_q.kind;
  assign out_chan.data_byte      = res_q.data_byte;
  assign out_chan.frame_address  = res_q.frame_address;
  assign out_chan.frame_function = res_q.frame_function;
  assign out_chan.frame_length   = res_q.frame_length;

`ifndef SYNTHESIS
  // A transferred byte is held in the input register on the next cycle
  a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_ready) |=> item_valid)
    else $error("accepted byte not held");

  // Never load a result over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(load && out_chan.valid && !out_chan.ready))
    else $error("result register overwritten");

  // A held byte that cannot move blocks new input
  a_block_in: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && !advance) |-> !in_ready)
    else $error("input taken while held byte stalled");
`endif

endmodule
